### rtl/rrms_pkg.sv
package rrms_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_CPUS    = 8;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W  = CNT_W + 1;
    localparam int SLOT_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int BUSY_W = $clog2(MAX_CPUS + 1);

    localparam int ID_W    = 16;
    localparam int TICK_W  = 16;
    localparam int NCPU_W  = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [NCPU_W-1:0] NUM_CPUS_RST = NCPU_W'(1);
    localparam logic [TICK_W-1:0] SLICE_RST    = TICK_W'(100);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TOT_W-1:0]  tot_t;
    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [BUSY_W-1:0] busy_t;
    typedef logic [2:0]        slot_field_t;

    typedef enum logic [0:0] {
        CMD_TICK   = 1'b0,
        CMD_SUBMIT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_STOP     = 2'd0,
        ACT_CONTINUE = 2'd1,
        ACT_REJECT   = 2'd2
    } action_t;

    typedef enum logic [0:0] {
        REG_NUM_CPUS = 1'b0,
        REG_SLICE    = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STOP = 4'b0010,
        ST_GAP  = 4'b0100,
        ST_FILL = 4'b1000
    } state_t;

    typedef struct packed {
        cmd_t            command;
        logic [ID_W-1:0] task_id;
    } item_t;

    typedef struct packed {
        action_t         action;
        logic [ID_W-1:0] task_id_res;
        slot_field_t     slot;
        logic            last;
    } result_t;

    function automatic busy_t idx_plus1(slot_idx_t i);
        busy_t r;
        r = busy_t'(i) + busy_t'(1);
        return r;
    endfunction

    function automatic ptr_t ptr_inc(ptr_t p);
        ptr_t r;
        r = (p == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0) : p + ptr_t'(1);
        return r;
    endfunction

endpackage

### rtl/rrms_ram.sv
module rrms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/round_robin_multi_slot_scheduler.sv
// Channel   Handshake                         Beat
// ------    --------------------------------  ---------------------------------------
// item      start & !busy                     command, task_id
// result    result_valid (one cycle, no stall) action, task_id_res, slot, last
// config    APB write: psel&penable&pwrite    num_cpus @ 0x0, slice_ticks @ 0x4
//
// A submit or a tick that does not end a slice leaves the scheduler idle. A
// rotation walks the busy slots (one stop per cycle, read from the slot
// memory), passes through a gap state so the last pushed id lands in the queue
// memory, then pops one continue per cycle.
// Reset clears all control state; the memories need no clearing pass.
// Results cannot be held off, so there is no output stall.
module round_robin_multi_slot_scheduler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rrms_pkg::item_t                  item,
    output logic                             result_valid,
    output rrms_pkg::result_t                result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrms_pkg::APB_AW-1:0]      paddr,
    input  logic [rrms_pkg::APB_DW-1:0]      pwdata,
    output logic [rrms_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    rrms_pkg::state_t    state_reg, state_next;
    rrms_pkg::slot_idx_t idx_reg, idx_next;
    rrms_pkg::busy_t     stop_n_reg, stop_n_next;
    rrms_pkg::busy_t     fill_n_reg, fill_n_next;
    rrms_pkg::busy_t     slots_busy_reg, slots_busy_next;
    rrms_pkg::ptr_t      head_reg, head_next;
    rrms_pkg::ptr_t      tail_reg, tail_next;
    rrms_pkg::cnt_t      count_reg, count_next;
    logic [rrms_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [rrms_pkg::NCPU_W-1:0] num_cpus_reg;
    logic [rrms_pkg::TICK_W-1:0] slice_reg;

    logic                p_valid_reg, p_valid_next;
    logic                p_stop_reg, p_stop_next;
    rrms_pkg::slot_idx_t p_slot_reg, p_slot_next;
    logic                p_last_reg, p_last_next;

    logic                res_valid_reg, res_valid_next;
    rrms_pkg::result_t   res_reg, res_next;

    logic                        accept;
    logic                        push;
    logic                        pop;
    logic                        fifo_we;
    logic [rrms_pkg::ID_W-1:0]   fifo_wdata;
    logic [rrms_pkg::ID_W-1:0]   fifo_rdata;
    logic                        slot_we;
    logic [rrms_pkg::ID_W-1:0]   slot_rdata;
    rrms_pkg::tot_t              total;
    rrms_pkg::busy_t             cpus_eff;
    rrms_pkg::busy_t             fill_calc;
    logic [rrms_pkg::TICK_W-1:0] slice_eff;
    logic [rrms_pkg::TICK_W-1:0] tick_inc;
    logic                        cfg_wr;

    assign accept = start && !busy;
    assign busy   = (state_reg != rrms_pkg::ST_IDLE) || p_valid_reg;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (rrms_pkg::reg_idx_t'(paddr[2]))
            rrms_pkg::REG_NUM_CPUS: prdata = rrms_pkg::APB_DW'(num_cpus_reg);
            rrms_pkg::REG_SLICE:    prdata = rrms_pkg::APB_DW'(slice_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cpus_reg <= rrms_pkg::NUM_CPUS_RST;
            slice_reg    <= rrms_pkg::SLICE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (rrms_pkg::reg_idx_t'(paddr[2]))
                rrms_pkg::REG_NUM_CPUS: num_cpus_reg <= pwdata[rrms_pkg::NCPU_W-1:0];
                rrms_pkg::REG_SLICE:    slice_reg    <= pwdata[rrms_pkg::TICK_W-1:0];
                default:                ;
            endcase
        end
    end

    // Queue memory: submits and stopped tasks push at the tail, fills pop at the head.
    assign push       = (accept && (item.command == rrms_pkg::CMD_SUBMIT) &&
                         (total < rrms_pkg::tot_t'(rrms_pkg::QUEUE_DEPTH)))
                        || (p_valid_reg && p_stop_reg);
    assign pop        = (state_reg == rrms_pkg::ST_FILL);
    assign fifo_we    = push;
    assign fifo_wdata = p_valid_reg ? slot_rdata : item.task_id;
    assign slot_we    = p_valid_reg && !p_stop_reg;

    rrms_ram #(
        .WIDTH (rrms_pkg::ID_W),
        .DEPTH (rrms_pkg::QUEUE_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata (fifo_wdata),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    rrms_ram #(
        .WIDTH (rrms_pkg::ID_W),
        .DEPTH (rrms_pkg::MAX_CPUS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (p_slot_reg),
        .wdata (fifo_rdata),
        .raddr (idx_reg),
        .rdata (slot_rdata)
    );

    always_comb
    begin
        total     = rrms_pkg::tot_t'(count_reg) + rrms_pkg::tot_t'(slots_busy_reg);
        slice_eff = (slice_reg == '0) ? rrms_pkg::TICK_W'(1) : slice_reg;
        tick_inc  = (tick_reg == '1) ? tick_reg : tick_reg + rrms_pkg::TICK_W'(1);
        if (num_cpus_reg == '0)
        begin
            cpus_eff = rrms_pkg::busy_t'(1);
        end
        else if (num_cpus_reg > rrms_pkg::NCPU_W'(rrms_pkg::MAX_CPUS))
        begin
            cpus_eff = rrms_pkg::busy_t'(rrms_pkg::MAX_CPUS);
        end
        else
        begin
            cpus_eff = rrms_pkg::busy_t'(num_cpus_reg);
        end
        // Every busy slot returns to the queue before the refill.
        fill_calc = (rrms_pkg::tot_t'(cpus_eff) <= total) ? cpus_eff
                                                           : rrms_pkg::busy_t'(total);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        stop_n_next     = stop_n_reg;
        fill_n_next     = fill_n_reg;
        slots_busy_next = slots_busy_reg;
        head_next       = pop ? rrms_pkg::ptr_inc(head_reg) : head_reg;
        tail_next       = push ? rrms_pkg::ptr_inc(tail_reg) : tail_reg;
        count_next      = count_reg + rrms_pkg::cnt_t'(push) - rrms_pkg::cnt_t'(pop);
        tick_next       = tick_reg;
        p_valid_next    = 1'b0;
        p_stop_next     = p_stop_reg;
        p_slot_next     = p_slot_reg;
        p_last_next     = p_last_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;

        // Memory data is back: emit the beat.
        if (p_valid_reg)
        begin
            res_valid_next       = 1'b1;
            res_next.action      = p_stop_reg ? rrms_pkg::ACT_STOP : rrms_pkg::ACT_CONTINUE;
            res_next.task_id_res = p_stop_reg ? slot_rdata : fifo_rdata;
            res_next.slot        = rrms_pkg::slot_field_t'(p_slot_reg);
            res_next.last        = p_last_reg;
        end

        unique case (state_reg)
            rrms_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == rrms_pkg::CMD_SUBMIT)
                    begin
                        if (total >= rrms_pkg::tot_t'(rrms_pkg::QUEUE_DEPTH))
                        begin
                            res_valid_next       = 1'b1;
                            res_next.action      = rrms_pkg::ACT_REJECT;
                            res_next.task_id_res = item.task_id;
                            res_next.slot        = '0;
                            res_next.last        = 1'b1;
                        end
                    end
                    else if (tick_inc >= slice_eff)
                    begin
                        tick_next       = '0;
                        stop_n_next     = slots_busy_reg;
                        fill_n_next     = fill_calc;
                        slots_busy_next = fill_calc;
                        idx_next        = '0;
                        if (slots_busy_reg != '0)
                        begin
                            state_next = rrms_pkg::ST_STOP;
                        end
                        else if (fill_calc != '0)
                        begin
                            state_next = rrms_pkg::ST_FILL;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            rrms_pkg::ST_STOP:
            begin
                p_valid_next = 1'b1;
                p_stop_next  = 1'b1;
                p_slot_next  = idx_reg;
                p_last_next  = (rrms_pkg::idx_plus1(idx_reg) == stop_n_reg) &&
                               (fill_n_reg == '0);
                if (rrms_pkg::idx_plus1(idx_reg) == stop_n_reg)
                begin
                    idx_next   = '0;
                    state_next = (fill_n_reg != '0) ? rrms_pkg::ST_GAP : rrms_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + rrms_pkg::slot_idx_t'(1);
                end
            end
            rrms_pkg::ST_GAP:
            begin
                // Let the last stopped id reach the queue memory before the first pop.
                state_next = rrms_pkg::ST_FILL;
            end
            rrms_pkg::ST_FILL:
            begin
                p_valid_next = 1'b1;
                p_stop_next  = 1'b0;
                p_slot_next  = idx_reg;
                p_last_next  = (rrms_pkg::idx_plus1(idx_reg) == fill_n_reg);
                if (rrms_pkg::idx_plus1(idx_reg) == fill_n_reg)
                begin
                    idx_next   = '0;
                    state_next = rrms_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + rrms_pkg::slot_idx_t'(1);
                end
            end
            default:
            begin
                state_next = rrms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrms_pkg::ST_IDLE;
            idx_reg        <= '0;
            stop_n_reg     <= '0;
            fill_n_reg     <= '0;
            slots_busy_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            tick_reg       <= '0;
            p_valid_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            stop_n_reg     <= stop_n_next;
            fill_n_reg     <= fill_n_next;
            slots_busy_reg <= slots_busy_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            tick_reg       <= tick_next;
            p_valid_reg    <= p_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_stop_reg <= p_stop_next;
        p_slot_reg <= p_slot_next;
        p_last_reg <= p_last_next;
        res_reg    <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Mid-rotation the refilled slots count before their ids leave the queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (total <= rrms_pkg::tot_t'(rrms_pkg::QUEUE_DEPTH)))
        else $error("queue plus busy slots exceed the queue depth");

    a_pipe_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |=> res_valid_reg)
        else $error("memory read did not produce a result beat");

    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.action == rrms_pkg::ACT_REJECT))
            |-> (result.last && (result.slot == '0) && $past(accept)))
        else $error("reject beat malformed or not caused by an accepted item");

    a_no_accept_mid_rotation: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rrms_pkg::ST_STOP) || (state_reg == rrms_pkg::ST_FILL)) |-> !accept)
        else $error("item accepted during a rotation");

endmodule

### tb/sv/rrms_slot_checker.sv
`timescale 1ns / 1ps

module rrms_slot_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  rrms_pkg::item_t                  item,
    input  logic                             result_valid,
    input  rrms_pkg::result_t                result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [rrms_pkg::APB_AW-1:0]      paddr,
    input  logic [rrms_pkg::APB_DW-1:0]      pwdata,
    output int                               pending,
    output int                               mismatches
);

    import rrms_pkg::*;

    localparam int MAX_PRINTS = 40;

    logic [ID_W-1:0]   ready_ids [QUEUE_DEPTH];
    logic [ID_W-1:0]   running_ids [MAX_CPUS];
    int unsigned       rd_pos;
    int unsigned       wr_pos;
    int unsigned       queued;
    int unsigned       running;
    int unsigned       ticks;
    logic [NCPU_W-1:0] cpus_reg;
    logic [TICK_W-1:0] slice_reg;
    result_t           due_actions [$];
    int                beats_seen;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic enqueue(input logic [ID_W-1:0] id);
        ready_ids[wr_pos] = id;
        wr_pos = (wr_pos + 1 >= QUEUE_DEPTH) ? 0 : wr_pos + 1;
        queued++;
    endtask

    function automatic logic [ID_W-1:0] dequeue();
        logic [ID_W-1:0] id;
        id = ready_ids[rd_pos];
        rd_pos = (rd_pos + 1 >= QUEUE_DEPTH) ? 0 : rd_pos + 1;
        queued--;
        return id;
    endfunction

    task automatic expect_action(input action_t act, input logic [ID_W-1:0] id,
                                 input int unsigned s, input logic fin);
        due_actions.push_back('{action: act, task_id_res: id,
                                slot: slot_field_t'(s), last: fin});
    endtask

    task automatic apply_submit(input logic [ID_W-1:0] id);
        if (queued + running >= QUEUE_DEPTH)
            expect_action(ACT_REJECT, id, 0, 1'b1);
        else
            enqueue(id);
    endtask

    task automatic apply_tick();
        int unsigned slice;
        int unsigned cpus;
        int unsigned s;
        int unsigned base;
        slice = (slice_reg == '0) ? 1 : slice_reg;
        cpus  = (cpus_reg == '0) ? 1 : ((cpus_reg > MAX_CPUS) ? MAX_CPUS : cpus_reg);
        if (ticks < 'hFFFF)
            ticks++;
        if (ticks < slice)
            return;
        ticks = 0;
        base  = due_actions.size();
        // stop every running slot and requeue its task in slot order
        for (s = 0; s < running && s < MAX_CPUS; s++)
        begin
            expect_action(ACT_STOP, running_ids[s], s, 1'b0);
            enqueue(running_ids[s]);
        end
        running = 0;
        for (s = 0; s < cpus && queued > 0; s++)
        begin
            running_ids[s] = dequeue();
            expect_action(ACT_CONTINUE, running_ids[s], s, 1'b0);
            running++;
        end
        if (due_actions.size() > base)
            due_actions[due_actions.size() - 1].last = 1'b1;
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (due_actions.size() == 0)
        begin
            report_mismatch($sformatf("beat %0d with nothing due: action %0d id %h slot %0d",
                                      beats_seen, got.action, got.task_id_res, got.slot));
            return;
        end
        want = due_actions.pop_front();
        if (got.action !== want.action || got.task_id_res !== want.task_id_res ||
            got.slot !== want.slot || got.last !== want.last)
            report_mismatch($sformatf(
                "beat %0d action %0d/%0d id %h/%h slot %0d/%0d last %0d/%0d",
                beats_seen, got.action, want.action, got.task_id_res, want.task_id_res,
                got.slot, want.slot, got.last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pos     = 0;
            wr_pos     = 0;
            queued     = 0;
            running    = 0;
            ticks      = 0;
            cpus_reg   = NUM_CPUS_RST;
            slice_reg  = SLICE_RST;
            beats_seen = 0;
            mismatches = 0;
            due_actions.delete();
            pending    = 0;
        end
        else
        begin
            // results first: an item accepted on this edge cannot cause one yet
            if (result_valid)
            begin
                check_result(result);
                beats_seen++;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_NUM_CPUS: cpus_reg  = pwdata[NCPU_W-1:0];
                    REG_SLICE:    slice_reg = pwdata[TICK_W-1:0];
                    default:      ;
                endcase
            end
            if (start && !busy)
            begin
                if (item.command == CMD_SUBMIT)
                    apply_submit(item.task_id);
                else
                    apply_tick();
            end
            pending = due_actions.size();
        end
    end

endmodule

### tb/sv/tb_round_robin_multi_slot_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_multi_slot_scheduler;

    import rrms_pkg::*;

    localparam int LIMIT_NS      = 4_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 36;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    item_t             item;
    logic              result_valid;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int pending;
    int mismatches;
    int idle_pct;
    int tasks_held;

    round_robin_multi_slot_scheduler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rrms_slot_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(input cmd_t cmd, input logic [ID_W-1:0] id);
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= '{command: cmd, task_id: id};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // tasks never leave, so this tracks how full the scheduler is
        if (cmd == CMD_SUBMIT && tasks_held < QUEUE_DEPTH)
            tasks_held++;
    endtask

    task automatic hold_items();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain(input int extra);
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (extra)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int unsigned cpus, input int unsigned slice);
        hold_items();
        drain(SETTLE_CYCLES);
        write_reg(REG_NUM_CPUS, APB_DW'(cpus));
        write_reg(REG_SLICE, APB_DW'(slice));
    endtask

    initial
    begin
        int phase;
        int k;
        int sub_pct;
        int unsigned slice;
        int unsigned pick;

        rst_n      = 1'b0;
        start      = 1'b0;
        item       = item_t'(0);
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_pct   = 0;
        tasks_held = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // slice not reached at the reset settings
        send_item(CMD_TICK, 16'h0000);
        // single slot, every tick rotates, nothing to run yet
        configure(1, 1);
        send_item(CMD_TICK, 16'hFFFF);
        send_item(CMD_SUBMIT, 16'h0000);
        send_item(CMD_SUBMIT, 16'hFFFF);
        send_item(CMD_SUBMIT, 16'h5A5A);
        // zero slot count and zero slice both act as one
        configure(0, 0);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_TICK, 16'h0000);
        // slot count above the maximum clamps to it
        configure(15, 0);
        send_item(CMD_SUBMIT, 16'h1234);
        send_item(CMD_SUBMIT, 16'h8001);
        send_item(CMD_TICK, 16'h0000);
        // shorten the slice below the ticks already counted
        configure(8, 5);
        repeat (3)
            send_item(CMD_TICK, 16'h0000);
        hold_items();
        drain(SETTLE_CYCLES);
        write_reg(REG_SLICE, APB_DW'(2));
        send_item(CMD_TICK, 16'h0000);
        configure(2, 65535);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SUBMIT, 16'h00FF);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 71;
                default: idle_pct = 22;
            endcase
            pick = $urandom_range(9, 0);
            if (pick < 6)
                slice = $urandom_range(4, 0);
            else if (pick < 8)
                slice = $urandom_range(20, 5);
            else if (pick == 8)
                slice = 65535;
            else
                slice = $urandom_range(65535, 0);
            configure($urandom_range(15, 0), slice);
            sub_pct = $urandom_range(40, 10);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 4 && k == PHASE_ITEMS / 2)
                begin
                    hold_items();
                    drain(0);
                end
                if ($urandom_range(99, 0) < sub_pct)
                    send_item(CMD_SUBMIT, ID_W'($urandom_range(65535, 0)));
                else
                    send_item(CMD_TICK, ID_W'($urandom_range(65535, 0)));
            end
        end

        // fill the scheduler, push past full, then rotate all eight slots
        idle_pct = 22;
        configure(8, 1);
        while (tasks_held < QUEUE_DEPTH)
            send_item(CMD_SUBMIT, ID_W'($urandom_range(65535, 0)));
        repeat (3)
            send_item(CMD_SUBMIT, ID_W'($urandom_range(65535, 0)));
        repeat (6)
            send_item(CMD_TICK, ID_W'($urandom_range(65535, 0)));

        hold_items();
        drain(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/rrms_pkg.sv
rtl/rrms_ram.sv
rtl/round_robin_multi_slot_scheduler.sv
tb/sv/rrms_slot_checker.sv
tb/sv/tb_round_robin_multi_slot_scheduler.sv
